@@ sv/djs_pkg.sv @@
// ----------------------------------------------------------------------------
// djs_pkg
// shared types and constants of the dag job dependency scheduler
// ----------------------------------------------------------------------------
package djs_pkg;

    localparam int CMD_W      = 2;
    localparam int HANDLE_W   = 7;
    localparam int FIN_W      = 6;
    localparam int STATUS_W   = 3;
    localparam int NODE_IDX_W = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD_NODE = 2'd0,
        CMD_ADD_DEP  = 2'd1,
        CMD_START    = 2'd2,
        CMD_FINISH   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_AFTER_START = 3'd1,
        ST_BAD_HANDLE  = 3'd2,
        ST_CYCLE       = 3'd3,
        ST_FULL        = 3'd4,
        ST_STARTED     = 3'd5,
        ST_NOT_RUNNING = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_RUN  = 2'd1,
        PH_DONE = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BFS,
        S_EDGE_RD,
        S_EDGE_WR,
        S_FIN_CHK,
        S_FIN_ROW,
        S_SCAN,
        S_UPD,
        S_FLUSH
    } fsm_t;

endpackage

@@ sv/djs_if.sv @@
// ----------------------------------------------------------------------------
// djs command and result channels
// valid/ready channels carrying one command or one result per transaction
// ----------------------------------------------------------------------------
interface djs_cmd_if
    import djs_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [HANDLE_W-1:0] dependent_node;
    logic [HANDLE_W-1:0] dependency_node;
    logic [FIN_W-1:0]    finished_node;

    modport source (output valid, cmd, dependent_node, dependency_node, finished_node,
                    input ready);
    modport sink   (input valid, cmd, dependent_node, dependency_node, finished_node,
                    output ready);
endinterface

interface djs_res_if
    import djs_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic                  node_valid;
    logic [NODE_IDX_W-1:0] node_index;
    logic                  last;
    logic                  all_done;

    modport source (output valid, status, node_valid, node_index, last, all_done,
                    input ready);
    modport sink   (input valid, status, node_valid, node_index, last, all_done,
                    output ready);
endinterface

@@ sv/djs_mem.sv @@
// ----------------------------------------------------------------------------
// djs_mem
// single-port-read, single-port-write memory with registered read and
// per-entry valid bits so that unwritten entries read as zero
// ----------------------------------------------------------------------------
module djs_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [WIDTH-1:0] q_reg;
    logic             q_ok_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            q_ok_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                q_ok_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = q_ok_reg ? q_reg : '0;

endmodule

@@ sv/dag_job_dependency_scheduler.sv @@
// ----------------------------------------------------------------------------
// dag_job_dependency_scheduler
// task graph scheduler: node and edge insertion with cycle check, start and
// finish processing with in-order release of ready nodes
// ----------------------------------------------------------------------------
// add node and commands rejected on decode give their result in the cycle after the transaction
// add dependency: reachability walk, one successor row per cycle
// start: one node state read per node
// finish: successor row read, then a scan of the added nodes with a state update per successor
// one command at a time; the row and node state memories set the pace
// reset: valid bits clear both memories at once, no clearing pass
module dag_job_dependency_scheduler
    import djs_pkg::*;
#(
    parameter int MAX_NODES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    djs_cmd_if.sink     req,
    djs_res_if.source   rsp
);

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int NW = 2 + CW;

    function automatic logic [AW-1:0] lowest(input logic [MAX_NODES-1:0] v);
        logic [AW-1:0] r;
        r = '0;
        for (int i = MAX_NODES - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = AW'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [MAX_NODES-1:0] onehot(input logic [AW-1:0] idx);
        return {{(MAX_NODES-1){1'b0}}, 1'b1} << idx;
    endfunction

    fsm_t state_reg, state_next;
    logic [CW-1:0] node_count_reg, node_count_next;
    logic          started_reg, started_next;
    logic [CW-1:0] pending_reg, pending_next;
    logic          out_valid_reg, out_valid_next;
    logic          held_reg, held_next;
    logic          inflight_reg, inflight_next;
    logic          fin_mode_reg, fin_mode_next;
    logic [CW-1:0] j_reg, j_next;

    logic [MAX_NODES-1:0] seen_reg, seen_next;
    logic [MAX_NODES-1:0] todo_reg, todo_next;
    logic [MAX_NODES-1:0] row_reg, row_next;
    logic [AW-1:0]        src_reg, src_next;
    logic [AW-1:0]        dst_reg, dst_next;
    logic [AW-1:0]        fin_reg, fin_next;
    logic [AW-1:0]        held_idx_reg, held_idx_next;

    logic [STATUS_W-1:0]   out_status_reg;
    logic                  out_nv_reg;
    logic [NODE_IDX_W-1:0] out_idx_reg;
    logic                  out_last_reg;
    logic                  out_done_reg;

    logic                 row_rd_en, row_wr_en;
    logic [AW-1:0]        row_rd_addr, row_wr_addr;
    logic [MAX_NODES-1:0] row_q, row_wr_data;
    logic                 node_rd_en, node_wr_en;
    logic [AW-1:0]        node_rd_addr, node_wr_addr;
    logic [NW-1:0]        node_q, node_wr_data;

    logic          push, push_ok;
    status_t       p_status;
    logic          p_nv;
    logic [AW-1:0] p_idx;
    logic          p_last;

    logic [MAX_NODES-1:0] merged, todo_m;
    logic [AW-1:0]        pick;
    phase_t               q_ph;
    logic [CW-1:0]        q_cnt, cnt_dec;
    logic                 rel, cand;

    djs_mem #(.DEPTH(MAX_NODES), .WIDTH(MAX_NODES), .AW(AW)) u_row_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (row_rd_en),
        .rd_addr (row_rd_addr),
        .rd_data (row_q),
        .wr_en   (row_wr_en),
        .wr_addr (row_wr_addr),
        .wr_data (row_wr_data)
    );

    djs_mem #(.DEPTH(MAX_NODES), .WIDTH(NW), .AW(AW)) u_node_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (node_rd_en),
        .rd_addr (node_rd_addr),
        .rd_data (node_q),
        .wr_en   (node_wr_en),
        .wr_addr (node_wr_addr),
        .wr_data (node_wr_data)
    );

    assign push_ok   = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && push_ok;

    assign q_ph    = phase_t'(node_q[NW-1:CW]);
    assign q_cnt   = node_q[CW-1:0];
    assign cnt_dec = (q_cnt != '0) ? q_cnt - CW'(1) : '0;
    assign merged  = seen_reg | (inflight_reg ? row_q : '0);
    assign todo_m  = todo_reg | (inflight_reg ? (row_q & ~seen_reg) : '0);
    assign pick    = lowest(todo_m);
    assign cand    = fin_mode_reg ? row_reg[j_reg[AW-1:0]] : 1'b1;
    assign rel     = fin_mode_reg ? ((cnt_dec == '0) && (q_ph == PH_WAIT)) : (q_cnt == '0);

    always_comb
    begin
        state_next      = state_reg;
        node_count_next = node_count_reg;
        started_next    = started_reg;
        pending_next    = pending_reg;
        held_next       = held_reg;
        inflight_next   = inflight_reg;
        fin_mode_next   = fin_mode_reg;
        j_next          = j_reg;
        seen_next       = seen_reg;
        todo_next       = todo_reg;
        row_next        = row_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        fin_next        = fin_reg;
        held_idx_next   = held_idx_reg;
        row_rd_en       = 1'b0;
        row_rd_addr     = '0;
        row_wr_en       = 1'b0;
        row_wr_addr     = '0;
        row_wr_data     = '0;
        node_rd_en      = 1'b0;
        node_rd_addr    = '0;
        node_wr_en      = 1'b0;
        node_wr_addr    = '0;
        node_wr_data    = '0;
        push            = 1'b0;
        p_status        = ST_OK;
        p_nv            = 1'b0;
        p_idx           = '0;
        p_last          = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid && push_ok)
                begin
                    unique case (cmd_t'(req.cmd))
                        CMD_ADD_NODE:
                        begin
                            push = 1'b1;
                            if (started_reg)
                            begin
                                p_status = ST_AFTER_START;
                            end
                            else if (node_count_reg == CW'(MAX_NODES))
                            begin
                                p_status = ST_FULL;
                            end
                            else
                            begin
                                p_nv            = 1'b1;
                                p_idx           = node_count_reg[AW-1:0];
                                node_count_next = node_count_reg + CW'(1);
                            end
                        end
                        CMD_ADD_DEP:
                        begin
                            if (started_reg)
                            begin
                                push     = 1'b1;
                                p_status = ST_AFTER_START;
                            end
                            else if ((req.dependent_node == req.dependency_node) ||
                                     (req.dependent_node >= HANDLE_W'(node_count_reg)) ||
                                     (req.dependency_node >= HANDLE_W'(node_count_reg)))
                            begin
                                push     = 1'b1;
                                p_status = ST_BAD_HANDLE;
                            end
                            else
                            begin
                                src_next      = req.dependent_node[AW-1:0];
                                dst_next      = req.dependency_node[AW-1:0];
                                seen_next     = onehot(req.dependent_node[AW-1:0]);
                                todo_next     = onehot(req.dependent_node[AW-1:0]);
                                inflight_next = 1'b0;
                                state_next    = S_BFS;
                            end
                        end
                        CMD_START:
                        begin
                            if (started_reg)
                            begin
                                push     = 1'b1;
                                p_status = ST_STARTED;
                            end
                            else
                            begin
                                started_next  = 1'b1;
                                pending_next  = node_count_reg;
                                j_next        = '0;
                                fin_mode_next = 1'b0;
                                state_next    = S_SCAN;
                            end
                        end
                        CMD_FINISH:
                        begin
                            if (!started_reg)
                            begin
                                push     = 1'b1;
                                p_status = ST_NOT_RUNNING;
                            end
                            else if (HANDLE_W'(req.finished_node) >= HANDLE_W'(node_count_reg))
                            begin
                                push     = 1'b1;
                                p_status = ST_BAD_HANDLE;
                            end
                            else
                            begin
                                node_rd_en   = 1'b1;
                                node_rd_addr = req.finished_node[AW-1:0];
                                fin_next     = req.finished_node[AW-1:0];
                                state_next   = S_FIN_CHK;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_BFS:
            begin
                seen_next = merged;
                if (todo_m == '0)
                begin
                    todo_next     = '0;
                    inflight_next = 1'b0;
                    if (!merged[dst_reg])
                    begin
                        state_next = S_EDGE_RD;
                    end
                    else if (push_ok)
                    begin
                        push       = 1'b1;
                        p_status   = ST_CYCLE;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    row_rd_en     = 1'b1;
                    row_rd_addr   = pick;
                    todo_next     = todo_m & ~onehot(pick);
                    inflight_next = 1'b1;
                end
            end
            S_EDGE_RD:
            begin
                row_rd_en    = 1'b1;
                row_rd_addr  = dst_reg;
                node_rd_en   = 1'b1;
                node_rd_addr = src_reg;
                state_next   = S_EDGE_WR;
            end
            S_EDGE_WR:
            begin
                if (push_ok)
                begin
                    push        = 1'b1;
                    row_wr_en   = 1'b1;
                    row_wr_addr = dst_reg;
                    row_wr_data = row_q | onehot(src_reg);
                    if (!row_q[src_reg])
                    begin
                        node_wr_en   = 1'b1;
                        node_wr_addr = src_reg;
                        node_wr_data = {PH_WAIT, q_cnt + CW'(1)};
                    end
                    state_next = S_IDLE;
                end
            end
            S_FIN_CHK:
            begin
                if (q_ph != PH_RUN)
                begin
                    if (push_ok)
                    begin
                        push       = 1'b1;
                        p_status   = ST_NOT_RUNNING;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    node_wr_en   = 1'b1;
                    node_wr_addr = fin_reg;
                    node_wr_data = {PH_DONE, q_cnt};
                    pending_next = (pending_reg != '0) ? pending_reg - CW'(1) : '0;
                    row_rd_en    = 1'b1;
                    row_rd_addr  = fin_reg;
                    state_next   = S_FIN_ROW;
                end
            end
            S_FIN_ROW:
            begin
                row_next      = row_q;
                j_next        = '0;
                fin_mode_next = 1'b1;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                if (j_reg == node_count_reg)
                begin
                    state_next = S_FLUSH;
                end
                else if (cand)
                begin
                    node_rd_en   = 1'b1;
                    node_rd_addr = j_reg[AW-1:0];
                    state_next   = S_UPD;
                end
                else
                begin
                    j_next = j_reg + CW'(1);
                end
            end
            S_UPD:
            begin
                if (!(rel && held_reg && !push_ok))
                begin
                    node_wr_en   = 1'b1;
                    node_wr_addr = j_reg[AW-1:0];
                    if (fin_mode_reg)
                    begin
                        node_wr_data = {rel ? PH_RUN : q_ph, cnt_dec};
                    end
                    else
                    begin
                        node_wr_data = {rel ? PH_RUN : q_ph, q_cnt};
                    end
                    if (rel)
                    begin
                        if (held_reg)
                        begin
                            push   = 1'b1;
                            p_nv   = 1'b1;
                            p_idx  = held_idx_reg;
                            p_last = 1'b0;
                        end
                        held_next     = 1'b1;
                        held_idx_next = j_reg[AW-1:0];
                    end
                    j_next     = j_reg + CW'(1);
                    state_next = S_SCAN;
                end
            end
            S_FLUSH:
            begin
                if (push_ok)
                begin
                    push       = 1'b1;
                    p_nv       = held_reg;
                    p_idx      = held_reg ? held_idx_reg : '0;
                    held_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = push ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= '0;
            started_reg    <= 1'b0;
            pending_reg    <= '0;
            out_valid_reg  <= 1'b0;
            held_reg       <= 1'b0;
            inflight_reg   <= 1'b0;
            fin_mode_reg   <= 1'b0;
            j_reg          <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            started_reg    <= started_next;
            pending_reg    <= pending_next;
            out_valid_reg  <= out_valid_next;
            held_reg       <= held_next;
            inflight_reg   <= inflight_next;
            fin_mode_reg   <= fin_mode_next;
            j_reg          <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seen_reg     <= seen_next;
        todo_reg     <= todo_next;
        row_reg      <= row_next;
        src_reg      <= src_next;
        dst_reg      <= dst_next;
        fin_reg      <= fin_next;
        held_idx_reg <= held_idx_next;
        if (push)
        begin
            out_status_reg <= p_status;
            out_nv_reg     <= p_nv;
            out_idx_reg    <= NODE_IDX_W'(p_idx);
            out_last_reg   <= p_last;
            out_done_reg   <= started_next && (pending_next == '0);
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.node_valid = out_nv_reg;
    assign rsp.node_index = out_idx_reg;
    assign rsp.last       = out_last_reg;
    assign rsp.all_done   = out_done_reg;

endmodule

@@ sv/djs_checker.sv @@
// ----------------------------------------------------------------------------
// djs_checker
// port-level checks of the scheduler's request and result channels
// ----------------------------------------------------------------------------
module djs_checker
    import djs_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  req_valid,
    input logic                  req_ready,
    input logic                  rsp_valid,
    input logic                  rsp_ready,
    input logic [STATUS_W-1:0]   rsp_status,
    input logic                  rsp_node_valid,
    input logic [NODE_IDX_W-1:0] rsp_node_index,
    input logic                  rsp_last,
    input logic                  rsp_all_done
);

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid &&
            $stable({rsp_status, rsp_node_valid, rsp_node_index, rsp_last, rsp_all_done}))
        else $error("result changed while stalled");

    a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_node_valid |-> rsp_node_index == '0)
        else $error("node index not zero without node valid");

    // an error status is always a single, final transaction
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != ST_OK |-> rsp_last && !rsp_node_valid)
        else $error("error result not final or carries a node");

    // a new command is taken only when the result slot can take its answer
    a_req_room: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |-> !rsp_valid || rsp_ready)
        else $error("command taken with result slot blocked");

endmodule

bind dag_job_dependency_scheduler djs_checker u_djs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_node_valid (rsp.node_valid),
    .rsp_node_index (rsp.node_index),
    .rsp_last       (rsp.last),
    .rsp_all_done   (rsp.all_done)
);

@@ verif/dag_job_dependency_scheduler_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dag_job_dependency_scheduler_tb
// drives add node, add dependency, start and finish commands into the
// scheduler and checks every result transaction against an in-bench model
// of the task graph, with random idling and stalls on both channels
// ----------------------------------------------------------------------------
module dag_job_dependency_scheduler_tb;
    import djs_pkg::*;

    typedef struct {
        status_t    status;
        logic       node_valid;
        logic [5:0] node_index;
        logic       last;
        logic       all_done;
    } sched_res_t;

    typedef struct {
        cmd_t       cmd;
        logic [6:0] dependent_node;
        logic [6:0] dependency_node;
        logic [5:0] finished_node;
        bit         typed;
        status_t    status;
    } cmd_row_t;

    logic clk;
    logic rst_n;
    int   errors;
    int   sent;
    bit   hold_rsp;
    bit   hold_req;

    djs_cmd_if req_if ();
    djs_res_if rsp_if ();

    dag_job_dependency_scheduler #(.MAX_NODES(64)) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if.sink),
        .rsp   (rsp_if.source)
    );

    // graph model
    logic [63:0] succ_rows [64];
    int          wait_cnt  [64];
    phase_t      node_ph   [64];
    int          node_cnt;
    bit          run_started;
    int          jobs_left;
    sched_res_t  exp_buf [4096];
    int          exp_wr;
    int          exp_rd;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic [63:0] live_nodes();
        if (node_cnt >= 64)
            return '1;
        return (64'd1 << node_cnt) - 64'd1;
    endfunction

    function automatic bit path_exists(int src, int dst);
        logic [63:0] seen;
        logic [63:0] nxt;
        seen = 64'd1 << src;
        for (int p = 0; p < 64; p++)
        begin
            nxt = seen;
            for (int i = 0; i < 64; i++)
                if (seen[i])
                    nxt |= succ_rows[i];
            nxt &= live_nodes();
            if (nxt == seen)
                break;
            seen = nxt;
        end
        return seen[dst];
    endfunction

    function automatic sched_res_t mk(status_t st, logic v, int idx);
        sched_res_t r;
        r.status     = st;
        r.node_valid = v;
        r.node_index = v ? idx[5:0] : 6'd0;
        r.last       = 1'b0;
        r.all_done   = 1'b0;
        return r;
    endfunction

    // applies one command to the graph model and queues its results
    function automatic status_t schedule_step(cmd_t c, int dn, int dy, int fn);
        sched_res_t  out [64];
        int          n;
        logic [63:0] row;
        n = 0;
        case (c)
            CMD_ADD_NODE:
                if (run_started)
                    out[n++] = mk(ST_AFTER_START, 0, 0);
                else if (node_cnt >= 64)
                    out[n++] = mk(ST_FULL, 0, 0);
                else
                begin
                    out[n++] = mk(ST_OK, 1, node_cnt);
                    node_cnt++;
                end
            CMD_ADD_DEP:
                if (run_started)
                    out[n++] = mk(ST_AFTER_START, 0, 0);
                else if (dn == dy || dn >= node_cnt || dy >= node_cnt)
                    out[n++] = mk(ST_BAD_HANDLE, 0, 0);
                else if (path_exists(dn, dy))
                    out[n++] = mk(ST_CYCLE, 0, 0);
                else
                begin
                    succ_rows[dy][dn] = 1'b1;
                    out[n++] = mk(ST_OK, 0, 0);
                end
            CMD_START:
                if (run_started)
                    out[n++] = mk(ST_STARTED, 0, 0);
                else
                begin
                    run_started = 1;
                    for (int i = 0; i < 64; i++)
                    begin
                        wait_cnt[i] = 0;
                        node_ph[i]  = PH_WAIT;
                    end
                    for (int i = 0; i < node_cnt; i++)
                    begin
                        row = succ_rows[i] & live_nodes();
                        for (int j = 0; j < 64; j++)
                            if (row[j])
                                wait_cnt[j] = (wait_cnt[j] + 1) & 127;
                    end
                    jobs_left = node_cnt;
                    for (int i = 0; i < node_cnt; i++)
                        if (wait_cnt[i] == 0)
                        begin
                            node_ph[i] = PH_RUN;
                            out[n++] = mk(ST_OK, 1, i);
                        end
                    if (n == 0)
                        out[n++] = mk(ST_OK, 0, 0);
                end
            default:
                if (!run_started)
                    out[n++] = mk(ST_NOT_RUNNING, 0, 0);
                else if (fn >= node_cnt)
                    out[n++] = mk(ST_BAD_HANDLE, 0, 0);
                else if (node_ph[fn] != PH_RUN)
                    out[n++] = mk(ST_NOT_RUNNING, 0, 0);
                else
                begin
                    row = succ_rows[fn] & live_nodes();
                    node_ph[fn] = PH_DONE;
                    if (jobs_left > 0)
                        jobs_left--;
                    for (int i = 0; i < 64; i++)
                    begin
                        if (!row[i])
                            continue;
                        if (wait_cnt[i] > 0)
                            wait_cnt[i]--;
                        if (wait_cnt[i] == 0 && node_ph[i] == PH_WAIT)
                        begin
                            node_ph[i] = PH_RUN;
                            out[n++] = mk(ST_OK, 1, i);
                        end
                    end
                    if (n == 0)
                        out[n++] = mk(ST_OK, 0, 0);
                end
        endcase
        for (int k = 0; k < n; k++)
        begin
            out[k].last     = (k == n - 1);
            out[k].all_done = run_started && jobs_left == 0;
            exp_buf[exp_wr] = out[k];
            exp_wr++;
        end
        return out[0].status;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic int req_idle_pct();
        if (sent < 140)
            return 29;
        if (sent < 280)
            return 49;
        return 0;
    endfunction

    function automatic int rsp_idle_pct();
        if (sent < 140)
            return 49;
        if (sent < 280)
            return 29;
        return 0;
    endfunction

    // valid stays high after the transaction until the next call or an explicit idle
    task automatic send_cmd(cmd_t c, int dn, int dy, int fn, bit typed, status_t want);
        status_t st;
        while ($urandom_range(99) < req_idle_pct() || hold_req)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid           <= 1'b1;
        req_if.cmd             <= c;
        req_if.dependent_node  <= dn[6:0];
        req_if.dependency_node <= dy[6:0];
        req_if.finished_node   <= fn[5:0];
        do
            @(posedge clk);
        while (!req_if.ready);
        st = schedule_step(c, dn, dy, fn);
        if (typed && st != want)
            report("typed status", st, want);
        sent++;
    endtask

    task automatic drain();
        while (exp_wr != exp_rd)
            @(posedge clk);
    endtask

    // result checker and receiver stalls
    initial
    begin
        sched_res_t e;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_if.valid && rsp_if.ready)
            begin
                if (exp_wr == exp_rd)
                begin
                    report("unexpected result transaction", 1, 0);
                end
                else
                begin
                    e = exp_buf[exp_rd];
                    exp_rd++;
                    if (rsp_if.status !== e.status)
                        report("status", rsp_if.status, e.status);
                    if (rsp_if.node_valid !== e.node_valid)
                        report("node_valid", rsp_if.node_valid, e.node_valid);
                    if (rsp_if.node_index !== e.node_index)
                        report("node_index", rsp_if.node_index, e.node_index);
                    if (rsp_if.last !== e.last)
                        report("last", rsp_if.last, e.last);
                    if (rsp_if.all_done !== e.all_done)
                        report("all_done", rsp_if.all_done, e.all_done);
                end
            end
            rsp_if.ready <= !hold_rsp && ($urandom_range(99) >= rsp_idle_pct());
        end
    end

    // long receiver hold-off
    initial
    begin
        wait (sent >= 100);
        hold_rsp = 1;
        repeat (400) @(posedge clk);
        hold_rsp = 0;
    end

    cmd_row_t directed [] = '{
        '{CMD_FINISH,   0,   0,  0, 1, ST_NOT_RUNNING},
        '{CMD_ADD_DEP,  1,   0,  0, 1, ST_BAD_HANDLE},
        '{CMD_ADD_NODE, 0,   0,  0, 1, ST_OK},
        '{CMD_ADD_NODE, 0,   0,  0, 1, ST_OK},
        '{CMD_ADD_NODE, 0,   0,  0, 1, ST_OK},
        '{CMD_ADD_NODE, 0,   0,  0, 1, ST_OK},
        '{CMD_ADD_DEP,  1,   0,  0, 1, ST_OK},
        '{CMD_ADD_DEP,  1,   0,  0, 1, ST_OK},
        '{CMD_ADD_DEP,  2,   2,  0, 1, ST_BAD_HANDLE},
        '{CMD_ADD_DEP,  127, 0,  0, 1, ST_BAD_HANDLE},
        '{CMD_ADD_DEP,  0,   127, 0, 1, ST_BAD_HANDLE},
        '{CMD_ADD_DEP,  0,   1,  0, 1, ST_CYCLE},
        '{CMD_ADD_DEP,  2,   1,  0, 0, ST_OK},
        '{CMD_ADD_DEP,  0,   2,  0, 0, ST_OK},
        '{CMD_ADD_DEP,  3,   0,  0, 0, ST_OK},
        '{CMD_FINISH,   0,   0,  63, 1, ST_NOT_RUNNING},
        '{CMD_START,    0,   0,  0, 0, ST_OK}
    };

    initial
    begin
        int a;
        int b;
        int run_list [64];
        int run_n;
        errors      = 0;
        sent        = 0;
        hold_rsp    = 0;
        hold_req    = 0;
        node_cnt    = 0;
        run_started = 0;
        jobs_left   = 0;
        exp_wr      = 0;
        exp_rd      = 0;
        foreach (succ_rows[i])
        begin
            succ_rows[i] = '0;
            wait_cnt[i]  = 0;
            node_ph[i]   = PH_WAIT;
        end
        rst_n                  <= 1'b0;
        req_if.valid           <= 1'b0;
        req_if.cmd             <= CMD_ADD_NODE;
        req_if.dependent_node  <= '0;
        req_if.dependency_node <= '0;
        req_if.finished_node   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows, the start row is held back until the graph is built
        for (int r = 0; r < directed.size() - 1; r++)
            send_cmd(directed[r].cmd, directed[r].dependent_node,
                     directed[r].dependency_node, directed[r].finished_node,
                     directed[r].typed, directed[r].status);

        // random graph build
        while (node_cnt < 64 || sent < 300)
        begin
            a = $urandom_range(99);
            if (node_cnt < 64 && (a < 25 || node_cnt < 6))
                send_cmd(CMD_ADD_NODE, $urandom_range(127), $urandom_range(127),
                         $urandom_range(63), 0, ST_OK);
            else if (a < 88)
            begin
                a = $urandom_range(node_cnt - 1);
                b = $urandom_range(node_cnt - 1);
                send_cmd(CMD_ADD_DEP, a, b, $urandom_range(63), 0, ST_OK);
            end
            else if (a < 94)
                send_cmd(CMD_ADD_DEP, $urandom_range(127), $urandom_range(127),
                         $urandom_range(63), 0, ST_OK);
            else
                send_cmd(CMD_FINISH, $urandom_range(127), $urandom_range(127),
                         $urandom_range(63), 0, ST_OK);
        end
        send_cmd(CMD_ADD_NODE, 0, 0, 0, 1, ST_FULL);

        // sender pause until the block is empty
        req_if.valid <= 1'b0;
        hold_req = 1;
        drain();
        hold_req = 0;
        send_cmd(directed[directed.size() - 1].cmd, 0, 0, 0, 0, ST_OK);
        send_cmd(CMD_START, 0, 0, 0, 1, ST_STARTED);
        send_cmd(CMD_ADD_NODE, 0, 0, 0, 1, ST_AFTER_START);
        send_cmd(CMD_ADD_DEP, 1, 0, 0, 1, ST_AFTER_START);

        // run the jobs to completion with some noise mixed in
        while (jobs_left > 0)
        begin
            run_n = 0;
            for (int i = 0; i < node_cnt; i++)
                if (node_ph[i] == PH_RUN)
                begin
                    run_list[run_n] = i;
                    run_n++;
                end
            a = $urandom_range(99);
            if (a < 80)
                send_cmd(CMD_FINISH, $urandom_range(127), $urandom_range(127),
                         run_list[$urandom_range(run_n - 1)], 0, ST_OK);
            else
                send_cmd(cmd_t'($urandom_range(3)), $urandom_range(127),
                         $urandom_range(127), $urandom_range(63), 0, ST_OK);
        end
        for (int k = 0; k < 6; k++)
            send_cmd(CMD_FINISH, 0, 0, $urandom_range(63), 0, ST_OK);

        req_if.valid <= 1'b0;
        drain();
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
